/* rtl/core/fcsd_pkg.sv */
// Shared constants, types and controller states of the frame change stability detector.
package fcsd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_WINDOW = 16;

   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int POS_WIDTH     = $clog2(STORE_DEPTH);
   localparam int PIXEL_WIDTH   = 32;
   localparam int DIM_WIDTH     = 11;
   localparam int SIZE_WIDTH    = 2 * DIM_WIDTH;
   localparam int LEN_WIDTH     = 5;
   localparam int RATIO_WIDTH   = 17;
   localparam int WIN_IDX_WIDTH = $clog2(MAX_WINDOW);
   localparam int COUNT_WIDTH   = 21;
   localparam int FRAMES_WIDTH  = 32;
   localparam int TOTAL_WIDTH   = 52;
   localparam int SUM_WIDTH     = COUNT_WIDTH + WIN_IDX_WIDTH;
   localparam int FRAC_WIDTH    = 16;
   localparam int PROD_WIDTH    = RATIO_WIDTH + COUNT_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(TOTAL_WIDTH + 1);

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = RATIO_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_WIDTH   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT  = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STABLE_RATIO  = CSR_INDEX_WIDTH'(3);

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;
   localparam logic [FRAMES_WIDTH-1:0] FRAMES_MAX = '1;
   localparam logic [TOTAL_WIDTH-1:0]  TOTAL_MAX  = '1;

   typedef struct packed {
      logic [DIM_WIDTH-1:0]   frame_width;
      logic [DIM_WIDTH-1:0]   frame_height;
      logic [LEN_WIDTH-1:0]   window_length;
      logic [RATIO_WIDTH-1:0] stable_ratio;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_width:   DIM_WIDTH'(1024),
      frame_height:  DIM_WIDTH'(1024),
      window_length: LEN_WIDTH'(16),
      stable_ratio:  RATIO_WIDTH'(0)
   };

   typedef enum logic [3:0] {
      ST_RUN,
      ST_DRAIN,
      ST_UPDATE,
      ST_TOTAL_GO,
      ST_TOTAL_WAIT,
      ST_SUM,
      ST_RECENT_GO,
      ST_RECENT_WAIT,
      ST_MULT,
      ST_EMIT,
      ST_FINISHED
   } state_type;

   typedef struct packed {
      logic take_pixels;
      logic process;
      logic frame_update;
      logic div_start;
      logic div_sel_recent;
      logic load_overall;
      logic sum_step;
      logic load_recent;
      logic clear_recent;
      logic mult;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic first_frame;
      logic div_done;
      logic sum_last;
      logic window_full;
      logic out_free;
      logic stable_now;
   } status_type;

endpackage

/* rtl/core/fcsd_if.sv */
// Handshake channel interfaces: pixel input, frame result output and register writes.
interface fcsd_req_if
   import fcsd_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface fcsd_rsp_if
   import fcsd_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] changed_pixels;
   logic [COUNT_WIDTH-1:0] recent_average;
   logic [COUNT_WIDTH-1:0] overall_average;
   logic                   stable;

   modport source (output valid, output changed_pixels, output recent_average,
                   output overall_average, output stable, input ready);
   modport sink   (input valid, input changed_pixels, input recent_average,
                   input overall_average, input stable, output ready);
endinterface

interface fcsd_csr_if
   import fcsd_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fcsd_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by both frame-end averages.
module fcsd_divider
   import fcsd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [TOTAL_WIDTH-1:0]  dividend,
   input  logic [FRAMES_WIDTH-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic [TOTAL_WIDTH-1:0]  quotient
);

   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic                     done_ff;
   logic [FRAMES_WIDTH-1:0]  rem_ff;
   logic [FRAMES_WIDTH-1:0]  divisor_ff;
   logic [TOTAL_WIDTH-1:0]   quo_ff;
   logic [FRAMES_WIDTH:0]    trial;
   logic [FRAMES_WIDTH:0]    diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[TOTAL_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == DIV_CNT_WIDTH'(1));
         if (start) begin
            cnt_ff <= DIV_CNT_WIDTH'(TOTAL_WIDTH);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[FRAMES_WIDTH-1:0] : trial[FRAMES_WIDTH-1:0];
         quo_ff <= {quo_ff[TOTAL_WIDTH-2:0], fits};
      end
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/fcsd_ctrl.sv */
// Controller state machine: pixel streaming and the frame-end sequence.
module fcsd_ctrl
   import fcsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_RUN: begin
            cmd.take_pixels = 1'b1;
            cmd.process     = 1'b1;
            if (status.frame_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.frame_update = 1'b1;
            state_in = status.first_frame ? ST_RUN : ST_TOTAL_GO;
         end
         ST_TOTAL_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_TOTAL_WAIT;
         end
         ST_TOTAL_WAIT: begin
            if (status.div_done) begin
               cmd.load_overall = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) state_in = ST_RECENT_GO;
         end
         ST_RECENT_GO: begin
            if (status.window_full) begin
               cmd.div_start      = 1'b1;
               cmd.div_sel_recent = 1'b1;
               state_in = ST_RECENT_WAIT;
            end else begin
               cmd.clear_recent = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_RECENT_WAIT: begin
            if (status.div_done) begin
               cmd.load_recent = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.stable_now ? ST_FINISHED : ST_RUN;
            end
         end
         ST_FINISHED: begin
            // items are taken and dropped until reset
            cmd.take_pixels = 1'b1;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule

/* rtl/core/fcsd_datapath.sv */
// Datapath: previous-frame store, change counting, window, averages and result register.
module fcsd_datapath
   import fcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   fcsd_req_if.sink    req,
   fcsd_rsp_if.source  rsp
);

   logic [PIXEL_WIDTH-1:0]   store_mem [STORE_DEPTH];
   logic [PIXEL_WIDTH-1:0]   stored_ff;
   logic [PIXEL_WIDTH-1:0]   pixel_ff;
   logic                     cmp_valid_ff;
   logic [POS_WIDTH-1:0]     pos_ff;
   logic                     first_frame_ff;
   logic [COUNT_WIDTH-1:0]   changes_ff;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [FRAMES_WIDTH-1:0]  frames_ff;
   logic [TOTAL_WIDTH-1:0]   total_ff;
   logic [COUNT_WIDTH-1:0]   win_ff [MAX_WINDOW];
   logic [SUM_WIDTH-1:0]     sum_ff;
   logic [WIN_IDX_WIDTH-1:0] sum_idx_ff;
   logic [COUNT_WIDTH-1:0]   overall_ff;
   logic [COUNT_WIDTH-1:0]   recent_ff;
   logic [PROD_WIDTH-1:0]    prod_ff;
   logic                     rsp_valid_ff;
   logic [COUNT_WIDTH-1:0]   rsp_changed_ff;
   logic [COUNT_WIDTH-1:0]   rsp_recent_ff;
   logic [COUNT_WIDTH-1:0]   rsp_overall_ff;
   logic                     rsp_stable_ff;

   logic [DIM_WIDTH-1:0]     width_c;
   logic [DIM_WIDTH-1:0]     height_c;
   logic [LEN_WIDTH-1:0]     len_c;
   logic [SIZE_WIDTH-1:0]    frame_size;
   logic [SIZE_WIDTH-1:0]    pos_next;
   logic                     last;
   logic                     act;
   logic [TOTAL_WIDTH:0]     total_sum;
   logic [TOTAL_WIDTH-1:0]   div_dividend;
   logic [FRAMES_WIDTH-1:0]  div_divisor;
   logic                     div_busy;
   logic                     div_done;
   logic [TOTAL_WIDTH-1:0]   div_quotient;
   logic [COUNT_WIDTH-1:0]   quotient_sat;
   logic [PROD_WIDTH-1:0]    scaled_recent;

   always_comb begin
      width_c = cfg.frame_width;
      if (cfg.frame_width == '0) width_c = DIM_WIDTH'(1);
      else if (cfg.frame_width > DIM_WIDTH'(MAX_WIDTH)) width_c = DIM_WIDTH'(MAX_WIDTH);
      height_c = cfg.frame_height;
      if (cfg.frame_height == '0) height_c = DIM_WIDTH'(1);
      else if (cfg.frame_height > DIM_WIDTH'(MAX_HEIGHT)) height_c = DIM_WIDTH'(MAX_HEIGHT);
      len_c = cfg.window_length;
      if (cfg.window_length == '0) len_c = LEN_WIDTH'(1);
      else if (cfg.window_length > LEN_WIDTH'(MAX_WINDOW)) len_c = LEN_WIDTH'(MAX_WINDOW);
   end

   assign frame_size = SIZE_WIDTH'(width_c) * SIZE_WIDTH'(height_c);
   assign pos_next   = SIZE_WIDTH'(pos_ff) + SIZE_WIDTH'(1);
   assign last       = (pos_next >= frame_size);

   assign req.ready = cmd.take_pixels;
   assign act       = req.valid && cmd.take_pixels && cmd.process;

   // read-before-write: the old pixel comes out while the new one goes in
   always_ff @(posedge clock) begin
      if (act) begin
         stored_ff           <= store_mem[pos_ff];
         store_mem[pos_ff]   <= req.pixel_word;
         pixel_ff            <= req.pixel_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         first_frame_ff <= 1'b1;
         changes_ff     <= '0;
      end else begin
         cmp_valid_ff <= act && !first_frame_ff;
         if (act) pos_ff <= last ? '0 : pos_next[POS_WIDTH-1:0];
         if (cmd.frame_update) begin
            first_frame_ff <= 1'b0;
            changes_ff     <= '0;
         end else if (cmp_valid_ff && (stored_ff != pixel_ff) && (changes_ff != COUNT_MAX)) begin
            changes_ff <= changes_ff + COUNT_WIDTH'(1);
         end
      end
   end

   assign total_sum = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(changes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         total_ff  <= '0;
         for (int i = 0; i < MAX_WINDOW; i++) win_ff[i] <= '0;
      end else if (cmd.frame_update && !first_frame_ff) begin
         if (frames_ff != FRAMES_MAX) frames_ff <= frames_ff + FRAMES_WIDTH'(1);
         total_ff <= total_sum[TOTAL_WIDTH] ? TOTAL_MAX : total_sum[TOTAL_WIDTH-1:0];
         for (int i = 0; i < MAX_WINDOW - 1; i++) begin
            if (i + 1 < int'(len_c)) win_ff[i] <= win_ff[i+1];
            else if (i + 1 == int'(len_c)) win_ff[i] <= changes_ff;
         end
         if (len_c == LEN_WIDTH'(MAX_WINDOW)) win_ff[MAX_WINDOW-1] <= changes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_update) begin
         count_ff   <= changes_ff;
         sum_ff     <= '0;
         sum_idx_ff <= '0;
      end else if (cmd.sum_step) begin
         sum_ff     <= sum_ff + SUM_WIDTH'(win_ff[sum_idx_ff]);
         sum_idx_ff <= sum_idx_ff + WIN_IDX_WIDTH'(1);
      end
   end

   assign div_dividend = cmd.div_sel_recent ? TOTAL_WIDTH'(sum_ff) : total_ff;
   assign div_divisor  = cmd.div_sel_recent ? FRAMES_WIDTH'(len_c) : frames_ff;

   fcsd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign quotient_sat = (|div_quotient[TOTAL_WIDTH-1:COUNT_WIDTH]) ? COUNT_MAX
                                                                    : div_quotient[COUNT_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_overall) overall_ff <= quotient_sat;
      if (cmd.load_recent) recent_ff <= quotient_sat;
      else if (cmd.clear_recent) recent_ff <= '0;
      if (cmd.mult) prod_ff <= PROD_WIDTH'(cfg.stable_ratio) * PROD_WIDTH'(overall_ff);
   end

   assign scaled_recent = PROD_WIDTH'({recent_ff, FRAC_WIDTH'(0)});

   always_comb begin
      status             = '0;
      status.frame_end   = act && last;
      status.first_frame = first_frame_ff;
      status.div_done    = div_done;
      status.sum_last    = ({1'b0, sum_idx_ff} == (len_c - LEN_WIDTH'(1)));
      status.window_full = (win_ff[0] != '0);
      status.out_free    = !rsp_valid_ff || rsp.ready;
      status.stable_now  = (win_ff[0] != '0) && (overall_ff != '0) && (scaled_recent < prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_changed_ff <= count_ff;
         rsp_recent_ff  <= recent_ff;
         rsp_overall_ff <= overall_ff;
         rsp_stable_ff  <= status.stable_now;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.changed_pixels  = rsp_changed_ff;
   assign rsp.recent_average  = rsp_recent_ff;
   assign rsp.overall_average = rsp_overall_ff;
   assign rsp.stable          = rsp_stable_ff;

   a_no_pixels_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !act)
      else $error("pixel processed during frame-end divide");

   a_emit_after_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !first_frame_ff)
      else $error("result emitted before a compared frame");

   a_update_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_update |-> !cmp_valid_ff)
      else $error("frame update while last compare still pending");

   a_frame_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (act && last) |=> (pos_ff == '0))
      else $error("position did not wrap at frame end");

endmodule

/* rtl/core/frame_change_stability_detector.sv */
// Top level of the frame change stability detector: register file and unit wiring.
//
// Usage: pixels arrive on req_ch (one 32-bit BGRA word per item, raster order).
// A frame is frame_width x frame_height items. The first frame only fills the
// previous-frame store; each later frame end gives one item on rsp_ch with the
// changed-pixel count, the window average, the overall average and the stable flag.
// Registers must be written through csr_ch (index 0..3, always ready) only while
// idle; the block itself does not enforce this. Throughput: one pixel per cycle
// inside a frame. After the last pixel of a compared frame req_ch.ready stays low
// through the drain and update states, the bit-serial divider for the overall
// average, the one-slot-per-cycle window sum, a second divide for the window
// average when the oldest window slot is nonzero, the product step and any wait
// for the output register; after the first frame only through drain and update.
// Results sit in an output register: a stalled receiver does not hold up the
// next frame; the next result load waits until the register is taken, with req_ch.ready low.
// Once a result flags stable, pixels are still taken but dropped until reset.
// Reset (synchronous) restores register defaults and clears counters and window;
// the pixel store needs no clearing since the first frame writes it.
module frame_change_stability_detector
   import fcsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fcsd_csr_if.sink   csr_ch,
   fcsd_req_if.sink   req_ch,
   fcsd_rsp_if.source rsp_ch
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FRAME_WIDTH:   cfg_ff.frame_width   <= csr_ch.data[DIM_WIDTH-1:0];
            REG_FRAME_HEIGHT:  cfg_ff.frame_height  <= csr_ch.data[DIM_WIDTH-1:0];
            REG_WINDOW_LENGTH: cfg_ff.window_length <= csr_ch.data[LEN_WIDTH-1:0];
            REG_STABLE_RATIO:  cfg_ff.stable_ratio  <= csr_ch.data[RATIO_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   fcsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   fcsd_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .status (status),
      .req    (req_ch),
      .rsp    (rsp_ch)
   );

endmodule
